// File: hw/rtl/sb64_pkg.sv
// ----------------------------------------------------------------------------
// sb64_pkg: shared constants and types for the block sorter
// Key width, store depth and the order-mapping function.
// ----------------------------------------------------------------------------
package sb64_pkg;
	localparam int KEY_W       = 32;
	localparam int STORE_DEPTH = 64;
	localparam int DEF_BLOCK_KEYS = 64;
	localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

	typedef logic [KEY_W-1:0] key_t;

	// map a key so that an unsigned compare gives the selected order
	function automatic key_t order_of(input key_t k, input logic uns);
		return uns ? k : (k ^ SIGN_FLIP);
	endfunction
endpackage

// File: hw/rtl/sort_block_of_64.sv
// ----------------------------------------------------------------------------
// sort_block_of_64: block sorter for up to BLOCK_KEYS 32-bit keys
// Keys are inserted into a memory-held sorted run one at a time; the run is
//   unloaded in ascending order when the block ends.
// ----------------------------------------------------------------------------
// Insertion: a key is taken in ST_IDLE; ST_RD reads the word below the hole
//   and ST_CMP either moves it up one slot and goes on down, each word read
//   through the single read port, or places the key; ST_IDLE then takes the
//   next key.
// One block at a time; busy stays high while inserting or unloading. Each
//   word is unloaded by ST_OUTRD (read) and ST_OUT (capture), with strobe
//   registered from ST_OUT; unloading starts after the last insertion ends.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset: clears the key count, the state and uns_q; memory holds
//   anything until written.
module sort_block_of_64
	import sb64_pkg::*;
#(
	parameter int BLOCK_KEYS = DEF_BLOCK_KEYS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [31:0] key_in,
	input  logic       last_in,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       strobe,
	output logic [31:0] key_out,
	output logic       last_out
);
	localparam int AW = $clog2(BLOCK_KEYS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] LIMIT = CW'(BLOCK_KEYS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1; // read the entry below the hole
	localparam logic [2:0] ST_CMP   = 3'd2; // compare and shift up, or place
	localparam logic [2:0] ST_OUTRD = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;   // keys held in the sorted run
	logic [CW-1:0] hole_q;    // free slot being moved down
	logic          end_q;     // block ends after this insertion
	logic          uns_q;
	key_t          new_q;
	logic [CW-1:0] rd_q;      // unload position

	logic          we;
	logic [AW-1:0] waddr, raddr;
	key_t          wdata, rdata;

	sb64_store #(.DEPTH(BLOCK_KEYS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;

	logic shift_up;
	logic move_up;
	assign shift_up = order_of(rdata, uns_q) > order_of(new_q, uns_q);
	// at slot 0 there is no word below: always place the new key
	assign move_up  = shift_up && (hole_q != '0);

	always_comb begin
		we    = 1'b0;
		waddr = hole_q[AW-1:0];
		wdata = new_q;
		raddr = AW'(hole_q - CW'(1));
		unique case (state_q)
			ST_CMP: begin
				we    = 1'b1;
				wdata = move_up ? rdata : new_q;
			end
			ST_OUTRD, ST_OUT: raddr = rd_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			hole_q   <= '0;
			end_q    <= 1'b0;
			uns_q    <= 1'b0;
			rd_q     <= '0;
			strobe   <= 1'b0;
			last_out <= 1'b0;
		end else begin
			strobe <= (state_q == ST_OUT);
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						uns_q <= cfg_data;
					end
					if (start) begin
						new_q   <= key_in;
						hole_q  <= count_q;
						end_q   <= last_in || (count_q + CW'(1) == LIMIT);
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// wait for the read data
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (move_up) begin
						// from slot 1 the word at slot 0 is already read:
						// place the key there next cycle
						hole_q  <= hole_q - CW'(1);
						state_q <= (hole_q == CW'(1)) ? ST_CMP : ST_RD;
					end else begin
						count_q <= count_q + CW'(1);
						if (end_q) begin
							rd_q    <= '0;
							state_q <= ST_OUTRD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUTRD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					key_out  <= rdata;
					last_out <= (rd_q + CW'(1) == count_q);
					if (rd_q + CW'(1) == count_q) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						rd_q    <= rd_q + CW'(1);
						state_q <= ST_OUTRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/sb64_store.sv
// ----------------------------------------------------------------------------
// sb64_store: key memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sb64_store
	import sb64_pkg::*;
#(
	parameter int DEPTH = STORE_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  key_t          wdata,
	input  logic [AW-1:0] raddr,
	output key_t          rdata
);
	key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sim/sort_block_of_64_test.sv
// ----------------------------------------------------------------------------
// sort_block_of_64_test: self-checking bench for the block sorter
// Feeds blocks of keys through the key port and predicts every sorted
// word in a scoreboard that keeps its own store of keys and the compare mode.
// ----------------------------------------------------------------------------
module sort_block_of_64_test;
	import sb64_pkg::*;

	localparam int CYCLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_KEYS = 170;

	// Predict the sorted words of each block and check them in order.
	class sorted_key_board;
		key_t pending_keys[$];
		key_t sorted_keys[$];
		bit sorted_lasts[$];
		bit mode_unsigned;
		int errors;

		function new();
			mode_unsigned = 0;
			errors = 0;
		endfunction

		function key_t rank_of(key_t k);
			return mode_unsigned ? k : {~k[31], k[30:0]};
		endfunction

		function void note_key(key_t k, bit last_flag);
			key_t held[$];
			key_t v;
			int j;
			pending_keys.push_back(k);
			if (!last_flag && pending_keys.size() < 64) return;
			held = pending_keys;
			// insertion sort on the mapped rank
			for (int i = 1; i < held.size(); i++) begin
				v = held[i];
				j = i;
				while (j > 0 && rank_of(held[j-1]) > rank_of(v)) begin
					held[j] = held[j-1];
					j--;
				end
				held[j] = v;
			end
			foreach (held[i]) begin
				sorted_keys.push_back(held[i]);
				sorted_lasts.push_back(i == held.size() - 1);
			end
			pending_keys.delete();
		endfunction

		function void check_word(key_t k, bit last_flag);
			if (sorted_keys.size() == 0) begin
				$display("%0t: unexpected word key=%h last=%b", $time, k, last_flag);
				errors++;
				return;
			end
			if (sorted_keys[0] !== k || sorted_lasts[0] !== last_flag) begin
				$display("%0t: mismatch expected key=%h last=%b actual key=%h last=%b",
					$time, sorted_keys[0], sorted_lasts[0], k, last_flag);
				errors++;
			end
			void'(sorted_keys.pop_front());
			void'(sorted_lasts.pop_front());
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [31:0] key_in = '0;
	logic last_in = 0;
	logic cfg_valid = 0;
	logic cfg_data = 0;
	logic busy, cfg_ready, strobe, last_out;
	logic [31:0] key_out;

	sorted_key_board board = new();
	int idle_cycles = 0;

	sort_block_of_64 DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.key_in(key_in), .last_in(last_in),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.strobe(strobe), .key_out(key_out), .last_out(last_out)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Check each strobed word and note each accepted key at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) board.check_word(key_out, last_out);
			if (start && !busy) board.note_key(key_in, last_in);
			if ((strobe) || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: stop when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Hold off for a random gap, mostly short, sometimes long; drop start meanwhile.
	task automatic hold_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one key word and hold it until the block takes it.
	task automatic send_key(key_t k, bit last_flag, bit gaps);
		if (gaps) hold_gap();
		start <= 1;
		key_in <= k;
		last_in <= last_flag;
		do @(posedge clk); while (busy);
	endtask

	// Wait for every expected word, then let the block settle.
	task automatic drain();
		start <= 0;
		while (board.sorted_keys.size() != 0 || board.pending_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the compare mode while the block is idle.
	task automatic write_mode(bit m);
		drain();
		cfg_valid <= 1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.mode_unsigned = m;
	endtask

	// Random key, with the extremes and their neighbours often.
	function automatic key_t pick_key();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	// Send a block of n keys; last marked below 64 keys, at random when the block fills itself.
	task automatic send_block(int n, bit gaps);
		for (int i = 0; i < n; i++)
			send_key(pick_key(), (i == n - 1) && (n < 64 || $urandom_range(0, 1)), gaps);
	endtask

	initial begin
		int sent;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single key, extremes in signed mode, ties.
		send_key(32'h1234_5678, 1, 0);
		send_key(32'h7FFF_FFFF, 0, 0);
		send_key(32'h8000_0000, 0, 0);
		send_key(32'hFFFF_FFFF, 0, 0);
		send_key(32'h0000_0000, 0, 0);
		send_key(32'h0000_0001, 0, 0);
		send_key(32'h0000_0001, 1, 0);
		write_mode(1);
		send_key(32'h7FFF_FFFF, 0, 0);
		send_key(32'h8000_0000, 0, 0);
		send_key(32'hFFFF_FFFF, 0, 0);
		send_key(32'h0000_0000, 0, 0);
		send_key(32'hAAAA_AAAA, 0, 0);
		send_key(32'h5555_5555, 1, 0);
		// Full block, its last flag set at random, ends by itself at 64 keys.
		write_mode(0);
		send_block(64, 1);
		drain();

		// Random blocks, mostly small, switching mode between phases.
		sent = 0;
		while (sent < RANDOM_KEYS) begin
			if ($urandom_range(0, 3) == 0) write_mode($urandom_range(0, 1));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
			send_block(n, $urandom_range(0, 3) != 0);
			sent += n;
		end
		write_mode(1);
		send_block(5, 1);
		write_mode(0);
		drain();

		if (board.errors == 0 && board.sorted_keys.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/sb64_pkg.sv
hw/rtl/sb64_store.sv
hw/rtl/sort_block_of_64.sv
sim/sort_block_of_64_test.sv
